[rtl/lcsp_pkg.sv]
// Package for the LED color sequence player: command and event codes, result type, constants.
`timescale 1ns / 1ps
`default_nettype none
package lcsp_pkg;

  // Input command codes.
  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_TICK   = 3'd1,
    CMD_START  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_RSTPOS = 3'd4
  } cmd_t;

  // Result event codes.
  typedef enum logic [1:0] {
    EVT_SHOW    = 2'd0,
    EVT_STARTED = 2'd1,
    EVT_STOPPED = 2'd2,
    EVT_POSRST  = 2'd3
  } evt_t;

  // One result item as it waits in the output queue.
  typedef struct packed {
    evt_t       evt;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       beat;
    logic [7:0] pos;
  } res_t;

  localparam int unsigned ADDR_W      = 9;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LANES       = 3;
  localparam logic [7:0]  STEP_RESET  = 8'd25;
  // Division of a byte address by three: (addr * 171) >> 9 is exact below 512.
  localparam logic [7:0]  DIV3_MUL    = 8'd171;
  localparam int unsigned DIV3_SHIFT  = 9;
  localparam int unsigned QUEUE_DEPTH = 3;

endpackage
`default_nettype wire

[rtl/lcsp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lcsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/led_color_sequence_player.sv]
// Top level of the LED color sequence player: pattern store, playback control, result queue.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_cmd, in_byte_addr, in_byte_value, in_load_last
//   out_     output     out_valid/out_stall  out_event_res, out_red, out_green, out_blue,
//                                            out_beat, out_position
//   cfg_     input      cfg_valid/cfg_ready  cfg_step_period
//
// One item is accepted per cycle while in_stall is low. Its result is first registered by the
// pattern store's read port and the stage registers beside it, and is then placed, colored,
// in the three-entry output queue.
// After reset the block clears the pattern store, one row of three bytes per cycle, and holds
// in_stall high until all (SQUARE_COUNT + 1) / 2 rows (128 at the default size) are cleared.
// in_stall comes from a register; it rises when the queue plus the item in flight fill all
// three queue entries, so a continuously drained output never stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module led_color_sequence_player #(
  parameter int unsigned SQUARE_COUNT = 256,
  parameter int unsigned ROW_LENGTH   = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input items
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_cmd,
  input  wire logic [8:0] in_byte_addr,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_load_last,
  // Result items
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_event_res,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic            out_beat,
  output logic [7:0]      out_position,
  // Configuration write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_step_period
);

  // Sizes derived from the parameters.
  localparam int unsigned STORE_BYTES = (SQUARE_COUNT * 3 + 1) / 2;
  localparam int unsigned ROWS        = (SQUARE_COUNT + 1) / 2;
  localparam int unsigned RW          = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PW          = $clog2(SQUARE_COUNT);
  localparam int unsigned CW          = (ROW_LENGTH > 1) ? $clog2(ROW_LENGTH) : 1;

  // Playback state.
  logic [PW-1:0] pos_r,  pos_nxt;
  logic [CW-1:0] col_r,  col_nxt;
  logic [7:0]    tick_r, tick_nxt;
  logic          play_r, play_nxt;
  logic [7:0]    step_r;

  // Clearing pass over the pattern store after reset.
  logic          clr_busy_r;
  logic [RW-1:0] clr_row_r;

  // Stage between the store read and the output queue.
  logic                a_vld_r, a_vld_nxt;
  lcsp_pkg::evt_t      a_evt_r, a_evt_nxt;
  logic                a_beat_r, a_beat_nxt;
  logic [7:0]          a_pos_r, a_pos_nxt;
  logic                a_odd_r, a_odd_nxt;

  // Output queue.
  lcsp_pkg::res_t q_mem_r [lcsp_pkg::QUEUE_DEPTH];
  logic [1:0]     q_wp_r, q_rp_r, q_cnt_r, q_cnt_nxt;
  logic           full_r;
  logic           push, pop;
  lcsp_pkg::res_t res_new;

  logic           acc;
  lcsp_pkg::cmd_t cmd;

  // Byte address to store row and byte lane.
  logic [16:0]    div_prod;
  logic [7:0]     wr_row_full;
  logic [8:0]     row_times3;
  logic [8:0]     lane_full;
  logic [1:0]     wr_lane;
  logic           addr_ok;

  logic           rd_en;
  logic [RW-1:0]  rd_row;
  logic [RW-1:0]  wr_row;
  logic [lcsp_pkg::BYTE_W-1:0] ram_q [lcsp_pkg::LANES];

  logic [7:0]     t_inc;
  logic [PW-1:0]  pos_adv;
  logic [CW-1:0]  col_adv;
  logic           start_ok;
  logic [3:0]     nib_r, nib_g, nib_b;

  assign acc       = in_valid && !in_stall;
  assign cmd       = lcsp_pkg::cmd_t'(in_cmd);
  assign in_stall  = clr_busy_r || full_r;
  assign cfg_ready = 1'b1;

  // The address is below 512, so the reciprocal multiply gives the exact row.
  assign div_prod    = 17'(in_byte_addr) * 17'(lcsp_pkg::DIV3_MUL);
  assign wr_row_full = 8'(div_prod >> lcsp_pkg::DIV3_SHIFT);
  assign row_times3  = 9'(wr_row_full) * 9'd3;
  assign lane_full   = in_byte_addr - row_times3;
  assign wr_lane     = lane_full[1:0];
  assign addr_ok     = 32'(in_byte_addr) < STORE_BYTES;
  assign wr_row      = clr_busy_r ? clr_row_r : RW'(wr_row_full);
  assign rd_row      = RW'(pos_r >> 1);

  // Next position and row column when the player steps forward.
  assign pos_adv  = (pos_r == PW'(SQUARE_COUNT - 1)) ? '0 : pos_r + PW'(1);
  assign col_adv  = (pos_adv == '0 || col_r == CW'(ROW_LENGTH - 1)) ? '0 : col_r + CW'(1);
  assign t_inc    = tick_r + 8'd1;
  assign start_ok = step_r != 8'd0;

  // Playback control: decides the new state and the event of each accepted item.
  always_comb begin
    pos_nxt    = pos_r;
    col_nxt    = col_r;
    tick_nxt   = tick_r;
    play_nxt   = play_r;
    a_vld_nxt  = 1'b0;
    a_evt_nxt  = lcsp_pkg::EVT_SHOW;
    a_beat_nxt = 1'b0;
    a_odd_nxt  = 1'b0;
    rd_en      = 1'b0;
    if (acc) begin
      case (cmd)
        lcsp_pkg::CMD_LOAD: begin
          if (in_load_last) begin
            pos_nxt   = '0;
            col_nxt   = '0;
            tick_nxt  = 8'd0;
            play_nxt  = start_ok;
            a_vld_nxt = 1'b1;
            a_evt_nxt = start_ok ? lcsp_pkg::EVT_STARTED : lcsp_pkg::EVT_STOPPED;
          end
        end
        lcsp_pkg::CMD_TICK: begin
          if (play_r) begin
            if (t_inc < step_r) begin
              tick_nxt = t_inc;
            end else begin
              // Show the current square, then step forward.
              tick_nxt   = 8'd0;
              rd_en      = 1'b1;
              a_odd_nxt  = pos_r[0];
              pos_nxt    = pos_adv;
              col_nxt    = col_adv;
              a_vld_nxt  = 1'b1;
              a_evt_nxt  = lcsp_pkg::EVT_SHOW;
              a_beat_nxt = col_adv == '0;
            end
          end
        end
        lcsp_pkg::CMD_START: begin
          pos_nxt   = '0;
          col_nxt   = '0;
          tick_nxt  = 8'd0;
          play_nxt  = start_ok;
          a_vld_nxt = 1'b1;
          a_evt_nxt = start_ok ? lcsp_pkg::EVT_STARTED : lcsp_pkg::EVT_STOPPED;
        end
        lcsp_pkg::CMD_STOP: begin
          play_nxt  = 1'b0;
          tick_nxt  = 8'd0;
          a_vld_nxt = 1'b1;
          a_evt_nxt = lcsp_pkg::EVT_STOPPED;
        end
        lcsp_pkg::CMD_RSTPOS: begin
          pos_nxt = '0;
          col_nxt = '0;
          if (play_r) begin
            tick_nxt = 8'd0;
            play_nxt = start_ok;
          end
          a_vld_nxt = 1'b1;
          a_evt_nxt = lcsp_pkg::EVT_POSRST;
        end
        default: begin
        end
      endcase
    end
  end

  // The event position is always the position after the item.
  assign a_pos_nxt = 8'(pos_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      col_r      <= '0;
      tick_r     <= 8'd0;
      play_r     <= 1'b0;
      step_r     <= lcsp_pkg::STEP_RESET;
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
      a_vld_r    <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      tick_r  <= tick_nxt;
      play_r  <= play_nxt;
      a_vld_r <= a_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_step_period;
      end
      if (clr_busy_r) begin
        if (clr_row_r == RW'(ROWS - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_row_r <= clr_row_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_evt_r  <= a_evt_nxt;
    a_beat_r <= a_beat_nxt;
    a_pos_r  <= a_pos_nxt;
    a_odd_r  <= a_odd_nxt;
  end

  // Pattern store: one RAM per byte lane, a row holds the three bytes of a square pair.
  for (genvar k = 0; k < lcsp_pkg::LANES; k++) begin : g_lane
    logic                        we;
    logic [lcsp_pkg::BYTE_W-1:0] wdata;

    assign we    = clr_busy_r ||
                   (acc && cmd == lcsp_pkg::CMD_LOAD && addr_ok && wr_lane == 2'(k));
    assign wdata = clr_busy_r ? '0 : in_byte_value;

    lcsp_ram #(
      .WIDTH (lcsp_pkg::BYTE_W),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wr_row),
      .wdata (wdata),
      .re    (rd_en),
      .raddr (rd_row),
      .rdata (ram_q[k])
    );
  end

  // Unpack the square's nibbles; an even square starts at the first byte of the row.
  always_comb begin
    if (a_odd_r) begin
      nib_r = ram_q[1][3:0];
      nib_g = ram_q[2][7:4];
      nib_b = ram_q[2][3:0];
    end else begin
      nib_r = ram_q[0][7:4];
      nib_g = ram_q[0][3:0];
      nib_b = ram_q[1][7:4];
    end
    res_new.evt   = a_evt_r;
    res_new.beat  = a_beat_r;
    res_new.pos   = a_pos_r;
    res_new.red   = '0;
    res_new.green = '0;
    res_new.blue  = '0;
    if (a_evt_r == lcsp_pkg::EVT_SHOW) begin
      res_new.red   = {nib_r, 4'd0};
      res_new.green = {nib_g, 4'd0};
      res_new.blue  = {nib_b, 4'd0};
    end
  end

  // Output queue of three entries.
  assign push      = a_vld_r;
  assign pop       = out_valid && !out_stall;
  assign q_cnt_nxt = q_cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 2'd0;
      q_rp_r  <= 2'd0;
      q_cnt_r <= 2'd0;
      full_r  <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      // Stall once the queue and the item in flight would take every entry.
      full_r  <= (3'(q_cnt_nxt) + 3'(a_vld_nxt)) >= 3'(lcsp_pkg::QUEUE_DEPTH);
      if (push) begin
        q_wp_r <= (q_wp_r == 2'(lcsp_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : q_wp_r + 2'd1;
      end
      if (pop) begin
        q_rp_r <= (q_rp_r == 2'(lcsp_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : q_rp_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wp_r] <= res_new;
    end
  end

  assign out_valid     = q_cnt_r != 2'd0;
  assign out_event_res = q_mem_r[q_rp_r].evt;
  assign out_red       = q_mem_r[q_rp_r].red;
  assign out_green     = q_mem_r[q_rp_r].green;
  assign out_blue      = q_mem_r[q_rp_r].blue;
  assign out_beat      = q_mem_r[q_rp_r].beat;
  assign out_position  = q_mem_r[q_rp_r].pos;

`ifndef NO_ASSERTIONS
  // A result in flight always finds a free queue entry.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> q_cnt_r != 2'd3)
    else $error("output queue overflow");

  // No item is taken while the store is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> in_stall)
    else $error("item accepted during store clear");

  // A shown square only comes from a running player.
  a_show_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && a_evt_r == lcsp_pkg::EVT_SHOW) |-> $past(play_r))
    else $error("square shown while stopped");

  // A stop command always leaves the player halted.
  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && cmd == lcsp_pkg::CMD_STOP) |=> !play_r)
    else $error("player still running after stop");

  // A tick while stopped gives no result.
  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && cmd == lcsp_pkg::CMD_TICK && !play_r) |=> !a_vld_r)
    else $error("result from tick while stopped");
`endif

endmodule
`default_nettype wire
